>>> rtl/core/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

>>> rtl/core/drrip_pkg.sv
package drrip_pkg;

  localparam int unsigned DEF_NUM_SETS      = 2048;
  localparam int unsigned DEF_NUM_WAYS      = 16;
  localparam int unsigned DEF_LEADER_COUNT  = 64;
  localparam int unsigned DEF_HIST_DEPTH    = 4;
  localparam int unsigned DEF_SELECTOR_BITS = 10;

  localparam int unsigned SET_IDX_W = 11;
  localparam int unsigned WAY_IDX_W = 4;
  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [1:0] RRPV_FAR   = 2'd3;
  localparam logic [1:0] RRPV_SRRIP = 2'd2;
  localparam logic [1:0] RRPV_NEAR  = 2'd0;
  localparam logic [1:0] DEAD_FULL  = 2'd3;
  localparam logic [1:0] DEAD_RESET = 2'd1;

  localparam logic OP_QUERY  = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECAY_LOG2,
    CFG_STREAM_THR,
    CFG_DEAD_THR,
    CFG_BIP_LOG2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SIGN_ZERO = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd2
  } sign_e;

endpackage

>>> rtl/core/drrip_ram.sv
module drrip_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/drrip_stream_det.sv
module drrip_stream_det #(
  parameter int unsigned HistDepth = drrip_pkg::DEF_HIST_DEPTH,
  localparam int unsigned PtrW = $clog2(HistDepth),
  localparam int unsigned RowW = drrip_pkg::ADDR_W + 2 * HistDepth + PtrW
) (
  input  logic [RowW-1:0]              row_i,
  input  logic [drrip_pkg::ADDR_W-1:0] addr_i,
  input  logic [2:0]                   thresh_i,
  output logic [RowW-1:0]              row_o,
  output logic                         stream_o
);

  localparam int unsigned CntW = $clog2(HistDepth + 1);

  logic [drrip_pkg::ADDR_W-1:0] last;
  logic [drrip_pkg::ADDR_W-1:0] delta;
  logic [HistDepth-1:0][1:0]    signs, signs_n;
  logic [PtrW-1:0]              ptr, ptr_n;
  logic [1:0]                   code;
  logic [CntW-1:0]              pos, neg;

  assign last  = row_i[RowW-1 -: drrip_pkg::ADDR_W];
  assign signs = row_i[PtrW +: 2 * HistDepth];
  assign ptr   = row_i[PtrW-1:0];
  assign delta = addr_i - last;

  always_comb begin
    if (delta == '0) begin
      code = drrip_pkg::SIGN_ZERO;
    end else if (delta[drrip_pkg::ADDR_W-1]) begin
      code = drrip_pkg::SIGN_NEG;
    end else begin
      code = drrip_pkg::SIGN_POS;
    end
    signs_n = signs;
    ptr_n   = ptr;
    // an all-zero last address means no earlier access to this set
    if (last != '0) begin
      signs_n[ptr] = code;
      ptr_n = (ptr == PtrW'(HistDepth - 1)) ? '0 : ptr + 1'b1;
    end
    pos = '0;
    neg = '0;
    for (int i = 0; i < HistDepth; i++) begin
      if (signs_n[i] == drrip_pkg::SIGN_POS) pos = pos + 1'b1;
      if (signs_n[i] == drrip_pkg::SIGN_NEG) neg = neg + 1'b1;
    end
  end

  assign stream_o = (5'(pos) >= 5'(thresh_i)) || (5'(neg) >= 5'(thresh_i));
  assign row_o    = {addr_i, signs_n, ptr_n};

endmodule

>>> rtl/core/drrip_replacement_with_stream_bypass_core.sv
// DRRIP replacement state for a NUM_SETS x NUM_WAYS cache with a per-set stream
// detector. One transaction at a time: a victim query or an update is registered,
// its set is read from memory in ST_READ, and the read-modify-write in ST_EXEC
// issues the result once the output is free; the next transaction is taken only
// after that. An update that reaches the decay period first walks the whole line
// memory in ST_SWEEP, one set per cycle, before its own read. After reset a
// clearing pass initializes both memories before the first input transaction is
// taken; configuration writes are accepted at any time. NUM_SETS, NUM_WAYS and
// HIST_DEPTH must be powers of two.
module drrip_replacement_with_stream_bypass_core #(
  parameter int unsigned NUM_SETS      = drrip_pkg::DEF_NUM_SETS,
  parameter int unsigned NUM_WAYS      = drrip_pkg::DEF_NUM_WAYS,
  parameter int unsigned LEADER_COUNT  = drrip_pkg::DEF_LEADER_COUNT,
  parameter int unsigned HIST_DEPTH    = drrip_pkg::DEF_HIST_DEPTH,
  parameter int unsigned SELECTOR_BITS = drrip_pkg::DEF_SELECTOR_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                opcode_i,
  input  logic [drrip_pkg::SET_IDX_W-1:0]     set_index_i,
  input  logic [drrip_pkg::WAY_IDX_W-1:0]     way_index_i,
  input  logic                                hit_i,
  input  logic [drrip_pkg::ADDR_W-1:0]        address_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [3:0]                          victim_way_o,
  output logic                                bypassed_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [drrip_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [drrip_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned SW      = $clog2(NUM_SETS);
  localparam int unsigned WW      = $clog2(NUM_WAYS);
  localparam int unsigned LineW   = 4 * NUM_WAYS;
  localparam int unsigned PtrW    = $clog2(HIST_DEPTH);
  localparam int unsigned DetW    = drrip_pkg::ADDR_W + 2 * HIST_DEPTH + PtrW;
  localparam int unsigned LeadEff = (LEADER_COUNT > NUM_SETS) ? NUM_SETS : LEADER_COUNT;
  localparam logic [SELECTOR_BITS-1:0] SelMax  = '1;
  localparam logic [SELECTOR_BITS-1:0] SelHalf = SelMax >> 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_READ,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;
  logic [SW:0] cnt_q, cnt_d;

  logic [4:0] cfg_decay_q;
  logic [2:0] cfg_stream_q;
  logic [1:0] cfg_dead_q;
  logic [3:0] cfg_bip_q;

  logic [SELECTOR_BITS-1:0] sel_q, sel_d;
  logic [19:0] acc_q, acc_d;
  logic [9:0]  bipc_q, bipc_d;

  logic                         op_q, hit_q;
  logic [SW-1:0]                set_q;
  logic [WW-1:0]                way_q;
  logic [drrip_pkg::ADDR_W-1:0] addr_q;

  logic       out_valid_q;
  logic [3:0] victim_q;
  logic       byp_q;

  logic in_acc, fire;
  logic [SW+drrip_pkg::SET_IDX_W-1:0] set_wide;
  logic [WW+drrip_pkg::WAY_IDX_W-1:0] way_wide;
  logic [19:0] decay_mask;
  logic [9:0]  bip_mask;

  // memory ports
  logic             line_we, line_re, det_we, det_re;
  logic [SW-1:0]    line_waddr, line_raddr, det_waddr;
  logic [LineW-1:0] line_wdata, line_rdata;
  logic [DetW-1:0]  det_wdata, det_rdata, det_new;
  logic             streaming;

  logic [NUM_WAYS-1:0][1:0] rr_cur, dd_cur, rr_new, dd_new, rr_aged, dd_swp;
  logic          f0, f1, f2, srrip_lead, bip_lead, bip_use, byp_n;
  logic [WW-1:0] v0, v1, v2, victim;
  logic [WW+3:0] victim_x;

  assign set_wide = {{SW{1'b0}}, set_index_i};
  assign way_wide = {{WW{1'b0}}, way_index_i};

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign fire        = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);
  assign cfg_ready_o = 1'b1;

  assign decay_mask = (cfg_decay_q >= 5'd20) ? '1 : 20'((21'd1 << cfg_decay_q) - 21'd1);
  assign bip_mask   = (cfg_bip_q >= 4'd10) ? '1 : 10'((11'd1 << cfg_bip_q) - 11'd1);

  assign {dd_cur, rr_cur} = line_rdata;
  assign srrip_lead = {1'b0, set_q} < (SW+1)'(LEADER_COUNT);
  assign bip_lead   = {1'b0, set_q} >= (SW+1)'(NUM_SETS - LeadEff);

  drrip_ram #(.Width(LineW), .Depth(NUM_SETS)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_waddr),
    .wdata_i (line_wdata),
    .re_i    (line_re),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  drrip_ram #(.Width(DetW), .Depth(NUM_SETS)) u_det_ram (
    .clk_i   (clk_i),
    .we_i    (det_we),
    .waddr_i (det_waddr),
    .wdata_i (det_wdata),
    .re_i    (det_re),
    .raddr_i (set_q),
    .rdata_o (det_rdata)
  );

  drrip_stream_det #(.HistDepth(HIST_DEPTH)) u_stream_det (
    .row_i    (det_rdata),
    .addr_i   (addr_q),
    .thresh_i (cfg_stream_q),
    .row_o    (det_new),
    .stream_o (streaming)
  );

  // victim search and line update
  always_comb begin
    f0 = 1'b0; f1 = 1'b0; f2 = 1'b0;
    v0 = '0;   v1 = '0;   v2 = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      rr_aged[w] = (rr_cur[w] == drrip_pkg::RRPV_FAR) ? rr_cur[w] : rr_cur[w] + 2'd1;
      dd_swp[w]  = (dd_cur[w] != 2'd0) ? dd_cur[w] - 2'd1 : 2'd0;
      if (rr_cur[w] == drrip_pkg::RRPV_FAR && dd_cur[w] == 2'd0) begin
        f0 = 1'b1; v0 = WW'(w);
      end
      if (rr_cur[w] == drrip_pkg::RRPV_FAR) begin
        f1 = 1'b1; v1 = WW'(w);
      end
      if (rr_aged[w] == drrip_pkg::RRPV_FAR && dd_cur[w] <= cfg_dead_q) begin
        f2 = 1'b1; v2 = WW'(w);
      end
    end
    victim = f0 ? v0 : (f1 ? v1 : (f2 ? v2 : '0));

    rr_new  = rr_cur;
    dd_new  = dd_cur;
    sel_d   = sel_q;
    bipc_d  = bipc_q;
    byp_n   = 1'b0;
    bip_use = bip_lead || (!srrip_lead && sel_q < SelHalf);
    if (op_q == drrip_pkg::OP_QUERY) begin
      if (!f0 && !f1) rr_new = rr_aged;
    end else if (streaming) begin
      rr_new[way_q] = drrip_pkg::RRPV_FAR;
      dd_new[way_q] = drrip_pkg::DEAD_FULL;
      byp_n = 1'b1;
    end else if (hit_q) begin
      rr_new[way_q] = drrip_pkg::RRPV_NEAR;
      dd_new[way_q] = dd_swp[way_q];
      if (srrip_lead && sel_d < SelMax) sel_d = sel_d + 1'b1;
      if (bip_lead && sel_d != '0) sel_d = sel_d - 1'b1;
    end else begin
      if (bip_use) begin
        bipc_d = bipc_q + 10'd1;
        rr_new[way_q] = ((bipc_d & bip_mask) == '0) ? drrip_pkg::RRPV_NEAR
                                                    : drrip_pkg::RRPV_FAR;
      end else begin
        rr_new[way_q] = drrip_pkg::RRPV_SRRIP;
      end
      dd_new[way_q] = drrip_pkg::DEAD_FULL;
    end
    if (!fire) begin
      sel_d  = sel_q;
      bipc_d = bipc_q;
    end
  end

  assign victim_x = {4'b0, victim};

  // sequencing and memory port muxing
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    acc_d      = acc_q;
    line_we    = 1'b0;
    line_re    = 1'b0;
    line_waddr = set_q;
    line_raddr = set_q;
    line_wdata = {dd_new, rr_new};
    det_we     = 1'b0;
    det_re     = 1'b0;
    det_waddr  = set_q;
    det_wdata  = det_new;
    case (state_q)
      ST_CLEAR: begin
        line_we    = 1'b1;
        det_we     = 1'b1;
        line_waddr = cnt_q[SW-1:0];
        det_waddr  = cnt_q[SW-1:0];
        line_wdata = {{NUM_WAYS{drrip_pkg::DEAD_RESET}}, {NUM_WAYS{drrip_pkg::RRPV_FAR}}};
        det_wdata  = '0;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q[SW-1:0] == SW'(NUM_SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_READ;
          cnt_d   = '0;
          if (opcode_i == drrip_pkg::OP_UPDATE) begin
            acc_d = acc_q + 20'd1;
            if ((acc_d & decay_mask) == '0) state_d = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        // read one set per cycle, write the previous one back decremented
        line_re    = 1'b1;
        line_raddr = cnt_q[SW-1:0];
        line_waddr = SW'(cnt_q - 1'b1);
        line_wdata = {dd_swp, rr_cur};
        line_we    = (cnt_q != '0);
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == (SW+1)'(NUM_SETS)) state_d = ST_READ;
      end
      ST_READ: begin
        line_re = 1'b1;
        det_re  = 1'b1;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (fire) begin
          line_we = 1'b1;
          det_we  = (op_q == drrip_pkg::OP_UPDATE);
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      cnt_q        <= '0;
      acc_q        <= '0;
      sel_q        <= SelHalf;
      bipc_q       <= '0;
      out_valid_q  <= 1'b0;
      cfg_decay_q  <= 5'd12;
      cfg_stream_q <= 3'd3;
      cfg_dead_q   <= 2'd1;
      cfg_bip_q    <= 4'd5;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      sel_q   <= sel_d;
      bipc_q  <= bipc_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (drrip_pkg::cfg_idx_e'(cfg_index_i))
          drrip_pkg::CFG_DECAY_LOG2: cfg_decay_q  <= cfg_data_i;
          drrip_pkg::CFG_STREAM_THR: cfg_stream_q <= cfg_data_i[2:0];
          drrip_pkg::CFG_DEAD_THR:   cfg_dead_q   <= cfg_data_i[1:0];
          drrip_pkg::CFG_BIP_LOG2:   cfg_bip_q    <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  // transaction and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= opcode_i;
      set_q  <= set_wide[SW-1:0];
      way_q  <= way_wide[WW-1:0];
      hit_q  <= hit_i;
      addr_q <= address_i;
    end
    if (fire) begin
      victim_q <= (op_q == drrip_pkg::OP_QUERY) ? victim_x[3:0] : 4'd0;
      byp_q    <= byp_n;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign victim_way_o = victim_q;
  assign bypassed_o   = byp_q;

endmodule

>>> rtl/core/drrip_checker.sv
`include "assert_macros.svh"

module drrip_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [3:0] victim_way_o,
  input logic       bypassed_o
);

  // one transaction in flight: acceptance closes the input for the next cycle
  `ASSERT_CLK(a_one_in_flight, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o)

  // a result is either a victim or a bypass flag, never both
  `ASSERT_NEVER(a_excl_result, clk_i, rst_ni, out_valid_o && bypassed_o && victim_way_o != 4'd0)

  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> out_valid_o)

  `ASSERT_CLK(a_out_stable, clk_i, rst_ni,
              (out_valid_o && out_stall_i) |=> ($stable(victim_way_o) && $stable(bypassed_o)))

endmodule

bind drrip_replacement_with_stream_bypass_core drrip_checker u_drrip_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .victim_way_o (victim_way_o),
  .bypassed_o   (bypassed_o)
);

>>> dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import drrip_pkg::*;

  localparam int NSETS = DEF_NUM_SETS;
  localparam int NWAYS = DEF_NUM_WAYS;
  localparam int NLINES = NSETS * NWAYS;
  localparam int LEADERS = DEF_LEADER_COUNT;
  localparam int HIST = DEF_HIST_DEPTH;
  localparam logic [9:0] SEL_TOP = 10'h3FF;
  localparam logic [9:0] SEL_MID = 10'h1FF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic        op;
    logic [10:0] set;
    logic [3:0]  way;
    logic        hit;
    logic [63:0] addr;
    bit          typed;
    logic [3:0]  victim;
    logic        bypass;
  } access_t;

  typedef struct {
    logic [3:0] victim;
    logic       bypass;
  } outcome_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        opcode_i;
  logic [10:0] set_index_i;
  logic [3:0]  way_index_i;
  logic        hit_i;
  logic [63:0] address_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  victim_way_o;
  logic        bypassed_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  drrip_replacement_with_stream_bypass_core dut (.*);

  // replacement state mirror
  logic [1:0]  line_rrpv [NLINES];
  logic [1:0]  line_dead [NLINES];
  logic [63:0] set_last_addr [NSETS];
  logic [7:0]  set_signs [NSETS];
  logic [1:0]  set_hptr [NSETS];
  logic [9:0]  psel;
  logic [19:0] update_count;
  logic [9:0]  bip_fills;
  logic [4:0]  decay_log2;
  logic [2:0]  stream_thr;
  logic [1:0]  dead_thr;
  logic [3:0]  bip_log2;

  outcome_t expected_q[$];
  int errors = 0;
  bit calm = 0;
  bit hold_req = 0;
  bit in_fire, out_fire, cfg_fire;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [19:0] period_mask(int lg, int width);
    if (lg >= width) return (20'd1 << width) - 1;
    return (20'd1 << lg) - 1;
  endfunction

  function automatic outcome_t replace_step(access_t a);
    outcome_t r;
    int base, idx, pos, neg, p;
    logic [63:0] d;
    logic [1:0] code;
    bit srrip_l, bip_l, sflag;
    base = a.set * NWAYS;
    idx = base + a.way;
    srrip_l = a.set < LEADERS;
    bip_l = a.set >= NSETS - LEADERS;
    r.victim = 0;
    r.bypass = 0;
    if (a.op == OP_QUERY) begin
      for (int w = 0; w < NWAYS; w++)
        if (line_rrpv[base+w] == RRPV_FAR && line_dead[base+w] == 0) begin
          r.victim = 4'(w);
          return r;
        end
      for (int w = 0; w < NWAYS; w++)
        if (line_rrpv[base+w] == RRPV_FAR) begin
          r.victim = 4'(w);
          return r;
        end
      for (int w = 0; w < NWAYS; w++)
        if (line_rrpv[base+w] != RRPV_FAR) line_rrpv[base+w]++;
      for (int w = 0; w < NWAYS; w++)
        if (line_rrpv[base+w] == RRPV_FAR && line_dead[base+w] <= dead_thr) begin
          r.victim = 4'(w);
          return r;
        end
      return r;
    end
    update_count++;
    if (set_last_addr[a.set] != 0) begin
      d = a.addr - set_last_addr[a.set];
      code = (d == 0) ? SIGN_ZERO : (d[63] ? SIGN_NEG : SIGN_POS);
      p = set_hptr[a.set];
      set_signs[a.set][2*p +: 2] = code;
      set_hptr[a.set] = 2'((p + 1) % HIST);
    end
    set_last_addr[a.set] = a.addr;
    pos = 0;
    neg = 0;
    for (int i = 0; i < HIST; i++) begin
      if (set_signs[a.set][2*i +: 2] == SIGN_POS) pos++;
      else if (set_signs[a.set][2*i +: 2] == SIGN_NEG) neg++;
    end
    sflag = pos >= stream_thr || neg >= stream_thr;
    if ((update_count & period_mask(decay_log2, 20)) == 0)
      for (int i = 0; i < NLINES; i++)
        if (line_dead[i] != 0) line_dead[i]--;
    if (sflag) begin
      line_rrpv[idx] = RRPV_FAR;
      line_dead[idx] = DEAD_FULL;
      r.bypass = 1;
    end else if (a.hit) begin
      line_rrpv[idx] = RRPV_NEAR;
      if (line_dead[idx] != 0) line_dead[idx]--;
      if (srrip_l && psel < SEL_TOP) psel++;
      if (bip_l && psel > 0) psel--;
    end else begin
      if (bip_l || (!srrip_l && psel < SEL_MID)) begin
        bip_fills++;
        line_rrpv[idx] = ((bip_fills & period_mask(bip_log2, 10)) == 0) ? RRPV_NEAR : RRPV_FAR;
      end else begin
        line_rrpv[idx] = RRPV_SRRIP;
      end
      line_dead[idx] = DEAD_FULL;
    end
    return r;
  endfunction

  task automatic send(access_t a);
    outcome_t r;
    while (!calm && $urandom_range(99) < 22) begin
      @(negedge clk_i);
      in_valid_i <= 0;
    end
    @(negedge clk_i);
    in_valid_i <= 1;
    opcode_i <= a.op;
    set_index_i <= a.set;
    way_index_i <= a.way;
    hit_i <= a.hit;
    address_i <= a.addr;
    do @(posedge clk_i); while (in_stall_o);
    r = replace_step(a);
    if (a.typed) begin
      r.victim = a.victim;
      r.bypass = a.bypass;
    end
    expected_q.push_back(r);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [4:0] val);
    @(negedge clk_i);
    in_valid_i <= 0;
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_DECAY_LOG2: decay_log2 = val;
      CFG_STREAM_THR: stream_thr = val[2:0];
      CFG_DEAD_THR:   dead_thr = val[1:0];
      CFG_BIP_LOG2:   bip_log2 = val[3:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 0;
    wait (expected_q.size() == 0);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic access_t random_access();
    access_t a;
    int pick;
    a.typed = 0;
    a.victim = 0;
    a.bypass = 0;
    a.op = 1'($urandom_range(1));
    pick = $urandom_range(9);
    if (pick < 3) a.set = 11'($urandom_range(LEADERS - 1));
    else if (pick < 5) a.set = 11'($urandom_range(NSETS - 1, NSETS - LEADERS));
    else if (pick < 8) a.set = 11'(100 + $urandom_range(7));
    else a.set = 11'($urandom);
    a.way = 4'($urandom);
    a.hit = 1'($urandom_range(1));
    pick = $urandom_range(9);
    // mostly strided walks so the stream detector trips
    if (pick < 4) a.addr = set_last_addr[a.set] + 64 * $urandom_range(1, 4);
    else if (pick < 7) a.addr = set_last_addr[a.set] - 64 * $urandom_range(1, 4);
    else if (pick < 8) a.addr = set_last_addr[a.set];
    else a.addr = {$urandom, $urandom};
    return a;
  endfunction

  // receiver side, sole driver of out_stall_i
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall_i = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1;
      end else begin
        out_stall_i <= !calm && $urandom_range(99) < 22;
      end
    end
  end

  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        e = expected_q.pop_front();
        if (victim_way_o !== e.victim) report_mismatch("victim_way", victim_way_o, e.victim);
        if (bypassed_o !== e.bypass) report_mismatch("bypassed", bypassed_o, e.bypass);
      end
    end
  end

  always @(posedge clk_i) begin
    int idle;
    in_fire = in_valid_i && !in_stall_o;
    out_fire = out_valid_o && !out_stall_i;
    cfg_fire = cfg_valid_i && cfg_ready_o;
    if (in_fire || out_fire || cfg_fire) idle = 0;
    else idle++;
    if (idle >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    access_t dir_rows[22];
    logic [4:0] phase_cfg[5][4];
    int phase_len[5];
    dir_rows = '{
      '{OP_QUERY, 11'd0, 4'd0, 1'b0, 64'd0, 1, 4'd0, 1'b0},
      '{OP_QUERY, 11'd2047, 4'd0, 1'b0, 64'd0, 1, 4'd0, 1'b0},
      '{OP_UPDATE, 11'd0, 4'd15, 1'b0, 64'd0, 1, 4'd0, 1'b0},
      '{OP_UPDATE, 11'd2047, 4'd15, 1'b1, '1, 1, 4'd0, 1'b0},
      '{OP_UPDATE, 11'd5, 4'd0, 1'b0, 64'd100, 0, 4'd0, 1'b0},
      '{OP_UPDATE, 11'd5, 4'd1, 1'b0, 64'd200, 0, 4'd0, 1'b0},
      '{OP_UPDATE, 11'd5, 4'd2, 1'b0, 64'd300, 0, 4'd0, 1'b0},
      '{OP_UPDATE, 11'd5, 4'd3, 1'b0, 64'd400, 1, 4'd0, 1'b1},
      '{OP_UPDATE, 11'd6, 4'd0, 1'b1, 64'd1000, 0, 4'd0, 1'b0},
      '{OP_UPDATE, 11'd6, 4'd1, 1'b1, 64'd900, 0, 4'd0, 1'b0},
      '{OP_UPDATE, 11'd6, 4'd2, 1'b1, 64'd800, 0, 4'd0, 1'b0},
      '{OP_UPDATE, 11'd6, 4'd3, 1'b1, 64'd700, 1, 4'd0, 1'b1},
      '{OP_UPDATE, 11'd7, 4'd4, 1'b0, 64'd50, 0, 4'd0, 1'b0},
      '{OP_UPDATE, 11'd7, 4'd5, 1'b0, 64'd50, 0, 4'd0, 1'b0},
      '{OP_QUERY, 11'd5, 4'd0, 1'b0, 64'd0, 0, 4'd0, 1'b0},
      '{OP_QUERY, 11'd6, 4'd0, 1'b0, 64'd0, 0, 4'd0, 1'b0},
      '{OP_UPDATE, 11'd1000, 4'd7, 1'b1, 64'h8000_0000_0000_0000, 0, 4'd0, 1'b0},
      '{OP_UPDATE, 11'd1984, 4'd0, 1'b0, 64'd1, 0, 4'd0, 1'b0},
      '{OP_UPDATE, 11'd63, 4'd1, 1'b0, 64'd2, 0, 4'd0, 1'b0},
      '{OP_UPDATE, 11'd64, 4'd2, 1'b0, 64'd3, 0, 4'd0, 1'b0},
      '{OP_QUERY, 11'd1984, 4'd0, 1'b0, 64'd0, 0, 4'd0, 1'b0},
      '{OP_QUERY, 11'd0, 4'd0, 1'b0, 64'd0, 0, 4'd0, 1'b0}
    };
    // decay, stream, dead, bip
    phase_cfg = '{'{5'd3, 5'd1, 5'd0, 5'd1}, '{5'd20, 5'd4, 5'd3, 5'd10},
                  '{5'd6, 5'd0, 5'd2, 5'd0}, '{5'd31, 5'd7, 5'd1, 5'd15},
                  '{5'd1, 5'd2, 5'd3, 5'd2}};
    phase_len = '{250, 250, 150, 200, 100};
    for (int i = 0; i < NLINES; i++) begin
      line_rrpv[i] = RRPV_FAR;
      line_dead[i] = DEAD_RESET;
    end
    for (int s = 0; s < NSETS; s++) begin
      set_last_addr[s] = 0;
      set_signs[s] = 0;
      set_hptr[s] = 0;
    end
    psel = SEL_MID;
    update_count = 0;
    bip_fills = 0;
    decay_log2 = 12;
    stream_thr = 3;
    dead_thr = 1;
    bip_log2 = 5;
    rst_ni = 0;
    in_valid_i = 0;
    opcode_i = 0;
    set_index_i = 0;
    way_index_i = 0;
    hit_i = 0;
    address_i = 0;
    cfg_valid_i = 0;
    cfg_index_i = CFG_DECAY_LOG2;
    cfg_data_i = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    foreach (dir_rows[i]) send(dir_rows[i]);
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_DECAY_LOG2, phase_cfg[ph][0]);
      write_reg(CFG_STREAM_THR, phase_cfg[ph][1]);
      write_reg(CFG_DEAD_THR, phase_cfg[ph][2]);
      write_reg(CFG_BIP_LOG2, phase_cfg[ph][3]);
      for (int n = 0; n < phase_len[ph]; n++) begin
        calm = (ph == 1 && n >= 50 && n < 120);
        if (ph == 1 && n == 60) hold_req = 1;
        send(random_access());
      end
      calm = 0;
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
